FILE: hdl/qpnc_pkg.sv
// Shared widths, field offsets and codes for the QUIC packet number codec.
// No dependencies; imported by quic_packet_number_codec.
`default_nettype none

package qpnc_pkg;

    // Field widths
    localparam int CMD_W    = 1;
    localparam int PN_W     = 64;
    localparam int REFV_W   = 1;
    localparam int REF_W    = 62;
    localparam int TRUNC_W  = 32;
    localparam int NBITS_W  = 6;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 3;
    localparam int ENC_W    = 32;
    localparam int DEC_W    = 63;
    localparam int BYTE_W   = 8;

    // Input word layout, lowest bit first
    localparam int IN_PN_LSB    = 0;
    localparam int IN_REFV_LSB  = IN_PN_LSB + PN_W;
    localparam int IN_REF_LSB   = IN_REFV_LSB + REFV_W;
    localparam int IN_TRUNC_LSB = IN_REF_LSB + REF_W;
    localparam int IN_NBITS_LSB = IN_TRUNC_LSB + TRUNC_W;
    localparam int IN_FIELDS_W  = IN_NBITS_LSB + NBITS_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + BYTE_W - 1) / BYTE_W) * BYTE_W;

    // Output word layout, lowest bit first
    localparam int OUT_FIELDS_W = STATUS_W + LEN_W + ENC_W + DEC_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + BYTE_W - 1) / BYTE_W) * BYTE_W;

    // Commands carried on tuser
    localparam logic [CMD_W-1:0] CMD_ENCODE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DECODE = 1'b1;

    // Result status
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_BITS = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // Legal truncated widths
    localparam logic [NBITS_W-1:0] PN_BITS_8  = 6'd8;
    localparam logic [NBITS_W-1:0] PN_BITS_16 = 6'd16;
    localparam logic [NBITS_W-1:0] PN_BITS_24 = 6'd24;
    localparam logic [NBITS_W-1:0] PN_BITS_32 = 6'd32;

    // Encoded lengths
    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

    // Largest legal packet number and one past it
    localparam logic [PN_W-1:0] PN_MAX    = (64'd1 << 62) - 64'd1;
    localparam logic [PN_W-1:0] PN_MAX_P1 = 64'd1 << 62;

endpackage

`default_nettype wire

FILE: hdl/quic_packet_number_codec.sv
// QUIC packet number codec (encode length selection and decode window).
// Depends on qpnc_pkg for widths, field layout and status codes.
//
// Usage:
//   Slave channel (i_s_*) takes one word per item: tuser selects encode or
//   decode, tdata carries the packet number, reference and truncated value.
//   Master channel (o_m_*) returns exactly one result word per item: status,
//   encoded length, big-endian encoded value and reconstructed number.
//   A result passes one input register, one pass of compare/add logic and
//   one result register before o_m_tvalid rises. Throughput is one item per
//   cycle while the receiver keeps i_m_tready high; the wide 64-bit span
//   subtract and window compares in that single pass set the clock limit.
//   Each stage advances when its successor is empty or being drained, so
//   o_s_tready stays high while a result waits as long as the input stage
//   is empty. When the receiver holds i_m_tready low with both stages full,
//   o_s_tready drops and the held result is stable.
//   A synchronous active-low reset empties both stages; no item is in flight
//   and no result is presented afterward.
`default_nettype none

module quic_packet_number_codec (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // slave word
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // tdata: packet_number, reference_valid, reference_pn, truncated_value,
    //        pn_bits, zero pad
    input  wire logic [qpnc_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // tuser: command
    input  wire logic [qpnc_pkg::CMD_W-1:0]         i_s_tuser,
    // master word
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // tdata: status, length_bytes, encoded_value, decoded_pn, zero pad
    output logic [qpnc_pkg::OUT_TDATA_W-1:0]        o_m_tdata
);
    import qpnc_pkg::*;

    // Input stage
    logic                r_in_vld;
    logic [CMD_W-1:0]    r_cmd;
    logic [PN_W-1:0]     r_pn;
    logic                r_refv;
    logic [REF_W-1:0]    r_ref;
    logic [TRUNC_W-1:0]  r_trunc;
    logic [NBITS_W-1:0]  r_nbits;

    // Result stage
    logic                r_out_vld;
    t_status             r_status;
    logic [LEN_W-1:0]    r_len;
    logic [ENC_W-1:0]    r_enc;
    logic [DEC_W-1:0]    r_dec;

    // Next result values
    t_status             n_status;
    logic [LEN_W-1:0]    n_len;
    logic [ENC_W-1:0]    n_enc;
    logic [DEC_W-1:0]    n_dec;

    logic                out_free;
    logic                in_accept;
    logic                adv;

    // Encode datapath
    logic [PN_W-1:0]     span;
    logic [LEN_W-1:0]    enc_len;
    logic [ENC_W-1:0]    enc_val;

    // Decode datapath
    logic                bits_ok;
    logic [PN_W-1:0]     win;
    logic [PN_W-1:0]     hwin;
    logic [PN_W-1:0]     wmask;
    logic [PN_W-1:0]     expected;
    logic [PN_W-1:0]     cand;
    logic [PN_W-1:0]     dec_val;

    localparam logic [PN_W-1:0] SPAN_MAX_1 = 64'd1 << (BYTE_W - 1);
    localparam logic [PN_W-1:0] SPAN_MAX_2 = 64'd1 << (2 * BYTE_W - 1);
    localparam logic [PN_W-1:0] SPAN_MAX_3 = 64'd1 << (3 * BYTE_W - 1);

    // Handshake: stages move when the next one is empty or draining
    assign out_free   = !r_out_vld || i_m_tready;
    assign adv        = r_in_vld && out_free;
    assign o_s_tready = !r_in_vld || out_free;
    assign in_accept  = i_s_tvalid && o_s_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd   <= i_s_tuser;
            r_pn    <= i_s_tdata[IN_PN_LSB +: PN_W];
            r_refv  <= i_s_tdata[IN_REFV_LSB];
            r_ref   <= i_s_tdata[IN_REF_LSB +: REF_W];
            r_trunc <= i_s_tdata[IN_TRUNC_LSB +: TRUNC_W];
            r_nbits <= i_s_tdata[IN_NBITS_LSB +: NBITS_W];
        end
    end

    // Encode: unacked span, then shortest length whose half-window covers it
    always_comb begin
        if (r_refv) begin
            span = r_pn - {2'b00, r_ref};
        end else begin
            span = r_pn + 64'd1;
        end
        if (span <= SPAN_MAX_1) begin
            enc_len = LEN_1;
        end else if (span <= SPAN_MAX_2) begin
            enc_len = LEN_2;
        end else if (span <= SPAN_MAX_3) begin
            enc_len = LEN_3;
        end else begin
            enc_len = LEN_4;
        end
        case (enc_len)
            LEN_1:   enc_val = {24'd0, r_pn[7:0]};
            LEN_2:   enc_val = {16'd0, r_pn[15:0]};
            LEN_3:   enc_val = {8'd0, r_pn[23:0]};
            default: enc_val = r_pn[31:0];
        endcase
    end

    // Decode: window size from bit count
    always_comb begin
        bits_ok = 1'b1;
        case (r_nbits)
            PN_BITS_8:  win = 64'd1 << 8;
            PN_BITS_16: win = 64'd1 << 16;
            PN_BITS_24: win = 64'd1 << 24;
            PN_BITS_32: win = 64'd1 << 32;
            default: begin
                bits_ok = 1'b0;
                win     = 64'd1 << 8;
            end
        endcase
    end

    // Decode: place truncated value in window around expected number
    always_comb begin
        hwin     = win >> 1;
        wmask    = win - 64'd1;
        expected = r_refv ? ({2'b00, r_ref} + 64'd1) : 64'd0;
        cand     = (expected & ~wmask) | ({32'd0, r_trunc} & wmask);
        if ((cand + hwin <= expected) && (cand < PN_MAX_P1 - win)) begin
            dec_val = cand + win;
        end else if ((cand > expected + hwin) && (cand >= win)) begin
            dec_val = cand - win;
        end else begin
            dec_val = cand;
        end
    end

    // Result select
    always_comb begin
        n_status = ST_OK;
        n_len    = LEN_NONE;
        n_enc    = '0;
        n_dec    = '0;
        if (r_cmd == CMD_ENCODE) begin
            if (r_pn > PN_MAX) begin
                n_status = ST_OVERFLOW;
            end else begin
                n_len = enc_len;
                n_enc = enc_val;
            end
        end else if (!bits_ok) begin
            n_status = ST_BAD_BITS;
        end else begin
            n_dec = dec_val[DEC_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_status <= n_status;
            r_len    <= n_len;
            r_enc    <= n_enc;
            r_dec    <= n_dec;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                         r_dec, r_enc, r_len, r_status};

    // Checks
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_len <= LEN_4))
        else $error("encoded length out of range");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_status != ST_OK) |-> (r_len == LEN_NONE && r_enc == '0
                                              && r_dec == '0))
        else $error("error result carries payload");

    a_enc_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_len == LEN_1) |-> (r_enc[31:8] == '0))
        else $error("one-byte encoding wider than a byte");

    a_enc_nodec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_len != LEN_NONE) |-> (r_dec == '0))
        else $error("encode result carries a decoded number");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld)
        else $error("input stage moved but no result present");

endmodule

`default_nettype wire

FILE: verif/quic_packet_number_codec_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for quic_packet_number_codec: directed and random encode/decode
// words with idle and stall phases, checked against an in-bench model. Depends on qpnc_pkg.

import qpnc_pkg::*;

// One input word, split into its fields
typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [PN_W-1:0]    pn;
    logic               ref_valid;
    logic [REF_W-1:0]   ref_pn;
    logic [TRUNC_W-1:0] trunc;
    logic [NBITS_W-1:0] nbits;
} t_pn_item;

// One result word, split into its fields
typedef struct {
    t_status            status;
    logic [LEN_W-1:0]   len;
    logic [ENC_W-1:0]   enc;
    logic [DEC_W-1:0]   dec;
} t_pn_result;

class codec_scoreboard;
    t_pn_result expected_results[$];
    int         errors;

    function new();
        errors = 0;
    endfunction

    // Bit-exact codec model for one word
    function automatic t_pn_result codec_result(t_pn_item it);
        t_pn_result  r;
        logic [63:0] span;
        logic [63:0] expected;
        logic [63:0] win;
        logic [63:0] hwin;
        logic [63:0] wmask;
        logic [63:0] cand;
        logic [63:0] full;
        logic [63:0] byte_mask;
        int          nb;
        int          nbytes;
        r.status = ST_OK;
        r.len    = LEN_NONE;
        r.enc    = '0;
        r.dec    = '0;
        if (it.cmd == CMD_ENCODE) begin
            if (it.pn > PN_MAX) begin
                r.status = ST_OVERFLOW;
            end else begin
                // unacked span, wraps when the reference is ahead
                span = it.ref_valid ? it.pn - {2'b00, it.ref_pn} : it.pn + 64'd1;
                nb = 0;
                for (int i = 0; i < 64; i++) begin
                    if (span[i]) nb = i + 1;
                end
                if (span == 64'd0) nb = 1;
                if ((64'd1 << (nb - 1)) < span) nb++;
                nbytes = (nb + BYTE_W - 1) / BYTE_W;
                if (nbytes < 1) nbytes = 1;
                if (nbytes > 4) nbytes = 4;
                byte_mask = (64'd1 << (BYTE_W * nbytes)) - 64'd1;
                r.len = nbytes[LEN_W-1:0];
                r.enc = it.pn[ENC_W-1:0] & byte_mask[ENC_W-1:0];
            end
        end else if (!(it.nbits inside {PN_BITS_8, PN_BITS_16, PN_BITS_24, PN_BITS_32})) begin
            r.status = ST_BAD_BITS;
        end else begin
            // window centered on the next expected number
            expected = it.ref_valid ? {2'b00, it.ref_pn} + 64'd1 : 64'd0;
            win   = 64'd1 << it.nbits;
            hwin  = win >> 1;
            wmask = win - 64'd1;
            cand  = (expected & ~wmask) | ({32'd0, it.trunc} & wmask);
            if (cand + hwin <= expected && cand < PN_MAX_P1 - win)
                full = cand + win;
            else if (cand > expected + hwin && cand >= win)
                full = cand - win;
            else
                full = cand;
            r.dec = full[DEC_W-1:0];
        end
        return r;
    endfunction

    function void note_item(t_pn_item it);
        expected_results.push_back(codec_result(it));
    endfunction

    function int outstanding();
        return expected_results.size();
    endfunction

    // Compare one result word with the oldest expectation
    function void check_word(logic [OUT_TDATA_W-1:0] w);
        t_pn_result       exp_r;
        logic [LEN_W-1:0] got_len;
        logic [ENC_W-1:0] got_enc;
        logic [DEC_W-1:0] got_dec;
        got_len = w[STATUS_W +: LEN_W];
        got_enc = w[STATUS_W + LEN_W +: ENC_W];
        got_dec = w[STATUS_W + LEN_W + ENC_W +: DEC_W];
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, w);
            errors++;
        end else begin
            exp_r = expected_results.pop_front();
            if (w[STATUS_W-1:0] !== exp_r.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                         w[STATUS_W-1:0]);
                errors++;
            end
            if (got_len !== exp_r.len) begin
                $display("%0t: length_bytes expected %0d actual %0d", $time, exp_r.len,
                         got_len);
                errors++;
            end
            if (got_enc !== exp_r.enc) begin
                $display("%0t: encoded_value expected %h actual %h", $time, exp_r.enc,
                         got_enc);
                errors++;
            end
            if (got_dec !== exp_r.dec) begin
                $display("%0t: decoded_pn expected %h actual %h", $time, exp_r.dec,
                         got_dec);
                errors++;
            end
        end
    endfunction
endclass

module quic_packet_number_codec_tb;

    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 300000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // tdata: packet_number, reference_valid, reference_pn, truncated_value, pn_bits, pad
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    // tuser: command
    logic [CMD_W-1:0]       i_s_tuser = CMD_ENCODE;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // tdata: status, length_bytes, encoded_value, decoded_pn, pad
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    codec_scoreboard sb = new();
    int              idle_pct = 0;
    int              stall_pct = 0;
    int              cycle_count = 0;
    logic [NBITS_W-1:0] legal_bits [4] = '{PN_BITS_8, PN_BITS_16, PN_BITS_24, PN_BITS_32};

    quic_packet_number_codec i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_word(o_m_tdata);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[quic_packet_number_codec] ERROR");
            $finish;
        end
    end

    function automatic t_pn_item make_item(logic [CMD_W-1:0] cmd, logic [PN_W-1:0] pn,
                                           logic refv, logic [REF_W-1:0] ref_pn,
                                           logic [TRUNC_W-1:0] trunc,
                                           logic [NBITS_W-1:0] nbits);
        t_pn_item it;
        it.cmd       = cmd;
        it.pn        = pn;
        it.ref_valid = refv;
        it.ref_pn    = ref_pn;
        it.trunc     = trunc;
        it.nbits     = nbits;
        return it;
    endfunction

    // Drive one word; entered and left at a falling edge
    task automatic send_item(t_pn_item it);
        logic [IN_TDATA_W-1:0] word;
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        word = '0;
        word[IN_PN_LSB    +: PN_W]    = it.pn;
        word[IN_REFV_LSB  +: REFV_W]  = it.ref_valid;
        word[IN_REF_LSB   +: REF_W]   = it.ref_pn;
        word[IN_TRUNC_LSB +: TRUNC_W] = it.trunc;
        word[IN_NBITS_LSB +: NBITS_W] = it.nbits;
        i_s_tdata  = word;
        i_s_tuser  = it.cmd;
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every pending result is back
    task automatic drain_results();
        i_s_tvalid = 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
    endtask

    // Reference number: anywhere, near zero, near the top, or of random width
    function automatic logic [REF_W-1:0] pick_reference();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(3))
            0:       return r[REF_W-1:0];
            1:       return REF_W'($urandom_range(600));
            2:       return PN_MAX[REF_W-1:0] - REF_W'($urandom_range(600));
            default: return REF_W'(r >> $urandom_range(2, 63));
        endcase
    endfunction

    task automatic random_item();
        t_pn_item    it;
        logic [63:0] delta;
        int          w;
        int          kind;
        it.cmd       = CMD_W'($urandom_range(1));
        it.ref_valid = ($urandom_range(9) != 0);
        it.ref_pn    = pick_reference();
        it.trunc     = $urandom;
        it.nbits     = legal_bits[$urandom_range(3)];
        it.pn        = {$urandom, $urandom};
        kind         = $urandom_range(9);
        if (it.cmd == CMD_ENCODE) begin
            w = $urandom_range(34);
            delta = {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
            if (kind == 1) begin
                // reference ahead of the number
                it.pn = {2'b00, it.ref_pn} - 64'($urandom_range(1, 1000));
            end else if (kind != 0) begin
                it.pn = it.ref_valid ? {2'b00, it.ref_pn} + delta : delta;
            end
        end else if (kind == 0) begin
            it.nbits = NBITS_W'($urandom_range(63));
        end
        send_item(it);
    endtask

    task automatic set_phase(int sender_idle, int receiver_stall);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed words, no idling
        set_phase(0, 0);
        send_item(make_item(CMD_ENCODE, 64'd0, 1'b0, '0, '0, '0));
        send_item(make_item(CMD_ENCODE, PN_MAX, 1'b0, '0, '1, '1));
        send_item(make_item(CMD_ENCODE, PN_MAX_P1, 1'b1, 62'd5, '0, '0));
        send_item(make_item(CMD_ENCODE, '1, 1'b0, '1, '1, '1));
        send_item(make_item(CMD_ENCODE, 64'd5, 1'b1, 62'd5, '0, '0));
        send_item(make_item(CMD_ENCODE, 64'd10, 1'b1, 62'd20, '0, '0));
        send_item(make_item(CMD_ENCODE, 64'hac5c02, 1'b1, 62'habe8b3, '0, '0));
        send_item(make_item(CMD_ENCODE, 64'hace8fe, 1'b1, 62'habe8b3, '0, '0));
        send_item(make_item(CMD_ENCODE, 64'd128, 1'b1, 62'd0, '0, '0));
        send_item(make_item(CMD_ENCODE, 64'd129, 1'b1, 62'd0, '0, '0));
        send_item(make_item(CMD_ENCODE, PN_MAX, 1'b1, PN_MAX[REF_W-1:0], '0, '0));
        send_item(make_item(CMD_ENCODE, 64'h7fff_ffff, 1'b1, 62'd0, '0, '0));
        send_item(make_item(CMD_DECODE, '0, 1'b1, 62'd100, 32'h12, 6'd0));
        send_item(make_item(CMD_DECODE, '0, 1'b1, 62'd100, 32'h12, 6'd63));
        send_item(make_item(CMD_DECODE, '0, 1'b1, 62'd100, 32'h12, 6'd7));
        send_item(make_item(CMD_DECODE, '0, 1'b0, '1, 32'hff, PN_BITS_8));
        send_item(make_item(CMD_DECODE, '0, 1'b1, 62'ha82f30ea, 32'h9b32, PN_BITS_16));
        send_item(make_item(CMD_DECODE, '0, 1'b1, PN_MAX[REF_W-1:0], 32'h0, PN_BITS_32));
        send_item(make_item(CMD_DECODE, '0, 1'b1, PN_MAX[REF_W-1:0], '1, PN_BITS_32));
        send_item(make_item(CMD_DECODE, '1, 1'b1, 62'd0, 32'hff, PN_BITS_8));
        send_item(make_item(CMD_DECODE, '0, 1'b1, 62'd0, '1, PN_BITS_8));
        send_item(make_item(CMD_DECODE, '0, 1'b1, 62'h123456789, 32'habcdef, PN_BITS_24));
        send_item(make_item(CMD_DECODE, '0, 1'b0, '0, 32'h8000_0000, PN_BITS_32));
        drain_results();

        // Random words over the idle/stall phases, pausing between phases
        set_phase(0, 0);
        repeat (RANDOM_ITEMS / 4) random_item();
        drain_results();
        set_phase(48, 0);
        repeat (RANDOM_ITEMS / 4) random_item();
        drain_results();
        set_phase(0, 48);
        repeat (RANDOM_ITEMS / 4) random_item();
        drain_results();
        set_phase(24, 24);
        repeat (RANDOM_ITEMS / 4) random_item();

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("[quic_packet_number_codec] OK");
        end else begin
            $display("[quic_packet_number_codec] ERROR");
        end
        $finish;
    end

endmodule
